FILE: hdl/ohlc_pkg.sv
// ----------------------------------------------------------------------------
// ohlc_pkg - shared types and constants for the OHLC bar aggregator
// Field widths, configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package ohlc_pkg;

	// payload widths
	localparam int TIME_BITS   = 32;
	localparam int PRICE_BITS  = 32;
	localparam int QTY_BITS    = 32;
	localparam int VOLUME_BITS = 48;
	localparam int LEN_BITS    = 17;
	localparam int CFG_BITS    = 32;

	// wide enough for any volume sum without overflow
	localparam int SUM_BITS = 65;

	// divider step count, one remainder step per dividend bit
	localparam int DIV_STEPS = TIME_BITS;
	localparam int CNT_BITS  = $clog2(DIV_STEPS);

	// configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_ORIGIN_TIME = 1'b0;
	localparam cfg_idx_t CFG_BAR_SECONDS = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_OPEN
	} state_t;

endpackage

FILE: hdl/ohlc_bar_aggregator_top.sv
// ----------------------------------------------------------------------------
// ohlc_bar_aggregator_top - OHLC bar aggregator
// Folds trades into one open bar aligned to origin_time / bar_seconds and
// emits the bar when a trade at or past its end arrives.
// ----------------------------------------------------------------------------
// Flow: a trade is taken only in ST_IDLE, then checked in ST_CHECK. A
//   merging trade returns to idle; a trade that opens a bar runs check,
//   32 radix-2 remainder steps on the shared bit-serial divider, then open.
//   A close registers the old bar into the output and waits while it is full.
// Reset: asynchronous, clears the open bar (no bar open) and the output.
// ----------------------------------------------------------------------------
module ohlc_bar_aggregator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  ohlc_pkg::cfg_idx_t                 cfg_index,
	input  logic [ohlc_pkg::CFG_BITS-1:0]      cfg_data,
	// trade requests
	input  logic                               trade_valid,
	output logic                               trade_ready,
	input  logic [ohlc_pkg::TIME_BITS-1:0]     trade_time,
	input  logic [ohlc_pkg::PRICE_BITS-1:0]    trade_price,
	input  logic [ohlc_pkg::QTY_BITS-1:0]      trade_quantity,
	// closed bars
	output logic                               bar_valid,
	input  logic                               bar_ready,
	output logic [ohlc_pkg::TIME_BITS-1:0]     bar_start,
	output logic [ohlc_pkg::PRICE_BITS-1:0]    bar_open,
	output logic [ohlc_pkg::PRICE_BITS-1:0]    bar_high,
	output logic [ohlc_pkg::PRICE_BITS-1:0]    bar_low,
	output logic [ohlc_pkg::PRICE_BITS-1:0]    bar_close,
	output logic [ohlc_pkg::VOLUME_BITS-1:0]   bar_volume
);

	localparam logic [ohlc_pkg::VOLUME_BITS-1:0] VOL_MAX = '1;

	// configuration
	logic [ohlc_pkg::TIME_BITS-1:0] origin_q;
	logic [ohlc_pkg::LEN_BITS-1:0]  bar_seconds_q;

	// sequencer
	ohlc_pkg::state_t state_q, state_d;
	logic [ohlc_pkg::CNT_BITS-1:0] cnt_q;

	// captured trade
	logic [ohlc_pkg::TIME_BITS-1:0]  time_q;
	logic [ohlc_pkg::PRICE_BITS-1:0] price_q;
	logic [ohlc_pkg::QTY_BITS-1:0]   qty_q;

	// divider
	logic [ohlc_pkg::TIME_BITS-1:0] dvd_q;
	logic [ohlc_pkg::LEN_BITS-1:0]  rem_q;
	logic [ohlc_pkg::LEN_BITS-1:0]  len_q;
	logic                           below_q;

	// open bar
	logic                             has_trade_q;
	logic [ohlc_pkg::TIME_BITS-1:0]   cur_start_q;
	logic [ohlc_pkg::PRICE_BITS-1:0]  cur_open_q;
	logic [ohlc_pkg::PRICE_BITS-1:0]  cur_high_q;
	logic [ohlc_pkg::PRICE_BITS-1:0]  cur_low_q;
	logic [ohlc_pkg::PRICE_BITS-1:0]  cur_close_q;
	logic [ohlc_pkg::VOLUME_BITS-1:0] cur_volume_q;

	// output register
	logic bar_valid_q;

	// control
	logic                            trade_acc;
	logic [ohlc_pkg::LEN_BITS-1:0]   len_eff;
	logic                            in_bar;
	logic                            out_free;
	logic                            do_merge;
	logic                            do_emit;
	logic                            do_start_div;
	logic [ohlc_pkg::LEN_BITS:0]     div_r;
	logic [ohlc_pkg::LEN_BITS-1:0]   rem_next;
	logic [ohlc_pkg::SUM_BITS-1:0]   vol_sum;
	logic [ohlc_pkg::VOLUME_BITS-1:0] vol_merge;
	logic [ohlc_pkg::VOLUME_BITS-1:0] vol_first;
	logic [ohlc_pkg::TIME_BITS-1:0]  new_start;

	assign trade_acc = trade_valid && trade_ready;
	assign len_eff   = (bar_seconds_q == '0) ? ohlc_pkg::LEN_BITS'(1) : bar_seconds_q;
	assign out_free  = !bar_valid_q || bar_ready;

	// trade falls before the open bar's end (end computed one bit wider)
	assign in_bar = ({1'b0, time_q}) <
		(({1'b0, cur_start_q}) + (ohlc_pkg::TIME_BITS+1)'(len_eff));

	// saturating volume
	assign vol_sum   = ohlc_pkg::SUM_BITS'(cur_volume_q) + ohlc_pkg::SUM_BITS'(qty_q);
	assign vol_merge = (vol_sum > ohlc_pkg::SUM_BITS'(VOL_MAX)) ? VOL_MAX
		: ohlc_pkg::VOLUME_BITS'(vol_sum);
	assign vol_first = (ohlc_pkg::SUM_BITS'(qty_q) > ohlc_pkg::SUM_BITS'(VOL_MAX)) ? VOL_MAX
		: ohlc_pkg::VOLUME_BITS'(qty_q);

	// one restoring remainder step
	assign div_r    = {rem_q, dvd_q[ohlc_pkg::TIME_BITS-1]};
	assign rem_next = (div_r >= {1'b0, len_q}) ? ohlc_pkg::LEN_BITS'(div_r - {1'b0, len_q})
		: div_r[ohlc_pkg::LEN_BITS-1:0];

	// aligned bucket start: trade time minus its offset into the bucket, or origin_time for a trade before it
	assign new_start = below_q ? origin_q : (time_q - ohlc_pkg::TIME_BITS'(rem_q));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q      <= '0;
			bar_seconds_q <= ohlc_pkg::LEN_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				ohlc_pkg::CFG_ORIGIN_TIME: origin_q      <= cfg_data[ohlc_pkg::TIME_BITS-1:0];
				ohlc_pkg::CFG_BAR_SECONDS: bar_seconds_q <= cfg_data[ohlc_pkg::LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ohlc_pkg::ST_IDLE:  if (trade_acc) state_d = ohlc_pkg::ST_CHECK;
			ohlc_pkg::ST_CHECK: begin
				if (!has_trade_q)
					state_d = ohlc_pkg::ST_DIV;
				else if (in_bar)
					state_d = ohlc_pkg::ST_IDLE;
				else if (out_free)
					state_d = ohlc_pkg::ST_DIV;
			end
			ohlc_pkg::ST_DIV:   if (cnt_q == '0) state_d = ohlc_pkg::ST_OPEN;
			ohlc_pkg::ST_OPEN:  state_d = ohlc_pkg::ST_IDLE;
			default:            state_d = ohlc_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		trade_ready  = 1'b0;
		do_merge     = 1'b0;
		do_emit      = 1'b0;
		do_start_div = 1'b0;
		case (state_q)
			ohlc_pkg::ST_IDLE:  trade_ready = 1'b1;
			ohlc_pkg::ST_CHECK: begin
				if (!has_trade_q) begin
					do_start_div = 1'b1;
				end else if (in_bar) begin
					do_merge = 1'b1;
				end else if (out_free) begin
					do_emit      = 1'b1;
					do_start_div = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ohlc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (do_start_div)
				cnt_q <= ohlc_pkg::CNT_BITS'(ohlc_pkg::DIV_STEPS - 1);
			else if (state_q == ohlc_pkg::ST_DIV)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// trade capture and divider datapath
	always_ff @(posedge clk) begin
		if (trade_acc) begin
			time_q  <= trade_time;
			price_q <= trade_price;
			qty_q   <= trade_quantity;
		end
		if (do_start_div) begin
			dvd_q   <= time_q - origin_q;
			rem_q   <= '0;
			len_q   <= len_eff;
			below_q <= time_q < origin_q;
		end else if (state_q == ohlc_pkg::ST_DIV) begin
			dvd_q <= {dvd_q[ohlc_pkg::TIME_BITS-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	// open bar: merge, or restart after the bucket is found
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_trade_q  <= 1'b0;
			cur_start_q  <= '0;
			cur_open_q   <= '0;
			cur_high_q   <= '0;
			cur_low_q    <= '1;
			cur_close_q  <= '0;
			cur_volume_q <= '0;
		end else if (do_merge) begin
			if (price_q > cur_high_q) cur_high_q <= price_q;
			if (price_q < cur_low_q)  cur_low_q  <= price_q;
			cur_close_q  <= price_q;
			cur_volume_q <= vol_merge;
		end else if (state_q == ohlc_pkg::ST_OPEN) begin
			has_trade_q  <= 1'b1;
			cur_start_q  <= new_start;
			cur_open_q   <= price_q;
			cur_high_q   <= price_q;
			cur_low_q    <= price_q;
			cur_close_q  <= price_q;
			cur_volume_q <= vol_first;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_valid_q <= 1'b0;
		end else if (do_emit) begin
			bar_valid_q <= 1'b1;
		end else if (bar_ready) begin
			bar_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			bar_start  <= cur_start_q;
			bar_open   <= cur_open_q;
			bar_high   <= cur_high_q;
			bar_low    <= cur_low_q;
			bar_close  <= cur_close_q;
			bar_volume <= cur_volume_q;
		end
	end

	assign bar_valid = bar_valid_q;

	// checks
	a_emit_needs_bar: assert property (@(posedge clk) disable iff (!arst_n)
		do_emit |-> has_trade_q)
		else $error("bar emitted with no open bar");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ohlc_pkg::ST_DIV && cnt_q == '0) |=> state_q == ohlc_pkg::ST_OPEN)
		else $error("divider did not finish after its last step");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ohlc_pkg::ST_OPEN |-> rem_q < len_q)
		else $error("bucket offset not below bar length");

	a_open_sets_bar: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ohlc_pkg::ST_OPEN |=> has_trade_q)
		else $error("bar not open after opening step");

	a_no_emit_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(bar_valid_q && !bar_ready) |-> !do_emit)
		else $error("output overwritten while stalled");

endmodule
